[rtl/twrs_pkg.sv]
// Shared types and constants for the tile window rebuild scheduler.
package twrs_pkg;
  localparam int GRID_SIDE  = 8;
  localparam int SLOT_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int SIDE_W     = $clog2(GRID_SIDE);
  localparam int POS_W      = 28;
  localparam int TILE_W     = 24;
  localparam int VER_W      = 16;
  localparam int CHUNK_W    = 11;
  localparam int BUDGET_W   = 7;
  localparam int RELIEF_W   = 17;
  localparam int RIN_W      = 18;
  localparam int DIST_W     = 64;
  localparam int PADDR_W    = 4;
  localparam int DATA_W     = 32;

  localparam logic [PADDR_W-1:0] ADDR_CHUNK  = 4'd0;
  localparam logic [PADDR_W-1:0] ADDR_BUDGET = 4'd4;
  localparam logic [PADDR_W-1:0] ADDR_RELIEF = 4'd8;

  localparam logic ACT_MOVE   = 1'b0;
  localparam logic ACT_RELIEF = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SCAN_RD, ST_SCAN_CHK, ST_MUL_X, ST_MUL_Y, ST_SUM,
    ST_SEL_INIT, ST_SEL_RD, ST_SEL_CMP, ST_EMIT, ST_OUT
  } state_t;
endpackage

[rtl/twrs_divider.sv]
// Iterative restoring divider: floor of a signed position by a positive span.
module twrs_divider import twrs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [POS_W-1:0] dividend,
  input  logic [CHUNK_W+3:0]      divisor,
  output logic signed [POS_W:0]   quotient
);
  localparam int CNT_W = $clog2(POS_W + 1);
  logic [POS_W-1:0]  mag_r, mag_nxt;
  logic [CHUNK_W+4:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, neg_r, neg_nxt;
  logic [CHUNK_W+4:0] trial;
  logic [POS_W:0]    qpos;

  always_comb begin
    mag_nxt = mag_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r;
    trial = {rem_r[CHUNK_W+3:0], mag_r[POS_W-1]};
    if (start) begin
      neg_nxt = dividend[POS_W-1];
      // ones complement gives floor for negatives: q = -((-a-1)/d) - 1
      mag_nxt = dividend[POS_W-1] ? ~dividend : dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(POS_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        mag_nxt = {mag_r[POS_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        mag_nxt = {mag_r[POS_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign qpos = {1'b0, mag_r};
  assign quotient = neg_r ? $signed(~qpos) : $signed(qpos);
endmodule

[rtl/tile_window_rebuild_scheduler.sv]
// Top level: slot table, scan and nearest-first selection sequencer.
// A move transaction runs the serial division (x then y) in ST_DIV, then scans the 64 slots:
// a current slot takes a read and a check (ST_SCAN_RD, ST_SCAN_CHK), a stale one also passes
// ST_MUL_X, ST_MUL_Y and ST_SUM, its distance going through the shared multiplier path. It
// then runs one selection pass per emitted slot: a read and a compare per scan position, then
// an emit, which waits while out_stall holds the previous result; ST_OUT waits until the last
// result is handed off. A relief transaction is handled in ST_IDLE. in_stall stays high from
// a move's acceptance until its last result leaves, or until the scan ends if no slot is stale.
module tile_window_rebuild_scheduler import twrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic signed [POS_W-1:0]  in_centre_x,
  input  logic signed [POS_W-1:0]  in_centre_y,
  input  logic signed [RIN_W-1:0]  in_relief_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SLOT_W-1:0]        out_slot_index,
  output logic signed [TILE_W-1:0] out_tile_x,
  output logic signed [TILE_W-1:0] out_tile_y,
  output logic [VER_W-1:0]         out_build_version,
  output logic                     out_last
);
  localparam int SPAN_W = CHUNK_W + 4;
  localparam int T_W    = POS_W + 1;   // tile coordinate
  localparam int D_W    = 33;          // doubled offset in 1/32 m, signed

  state_t state_r, state_nxt;
  logic [CHUNK_W-1:0]  cfg_chunk_r;
  logic [BUDGET_W-1:0] cfg_budget_r;
  logic [RELIEF_W-1:0] cfg_relief_r, relief_r, relief_nxt;
  logic [VER_W-1:0]    ver_r, ver_nxt;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;

  // slot table and candidate memory
  logic [TILE_W-1:0] tx_mem [SLOT_COUNT];
  logic [TILE_W-1:0] ty_mem [SLOT_COUNT];
  logic [VER_W-1:0]  vr_mem [SLOT_COUNT];
  logic [DIST_W-1:0] cd_mem [SLOT_COUNT];   // indexed by scan order
  logic [SLOT_COUNT-1:0] cand_r, cand_nxt;

  logic signed [POS_W-1:0] cx_r, cy_r;
  logic signed [T_W-1:0]   fx_r, fy_r, fx_nxt, fy_nxt;
  logic [SLOT_W-1:0]       idx_r, idx_nxt, best_r, best_nxt;
  logic [DIST_W-1:0]       bestd_r, bestd_nxt, acc_r, acc_nxt;
  logic                    found_r, found_nxt;
  logic [SLOT_W:0]         left_r, left_nxt;
  logic                    divsel_r, divsel_nxt;
  logic                    ov_r, ov_nxt;
  logic [SLOT_W-1:0]       os_r, os_nxt;
  logic [TILE_W-1:0]       ox_r, ox_nxt, oy_r, oy_nxt;
  logic                    ol_r, ol_nxt;
  logic [TILE_W-1:0]       rd_tx_r, rd_ty_r;
  logic [VER_W-1:0]        rd_v_r;
  logic [DIST_W-1:0]       rd_d_r;
  logic                    wr_en, cd_wr;
  logic [SLOT_W-1:0]       wr_slot;
  logic [SLOT_W-1:0]       rd_addr;

  logic [CHUNK_W-1:0] chunk_c;
  logic [SPAN_W-1:0]  span;
  logic div_start;
  logic signed [T_W-1:0] div_q;
  logic signed [POS_W-1:0] div_a;

  assign chunk_c = (cfg_chunk_r == '0) ? CHUNK_W'(1) :
                   (cfg_chunk_r > CHUNK_W'(1024)) ? CHUNK_W'(1024) : cfg_chunk_r;
  assign span = {chunk_c, 4'b0};

  logic [5:0] div_cnt_r, div_cnt_nxt;
  twrs_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(span),
    .quotient(div_q)
  );

  // scan position -> tile and slot
  logic [SIDE_W-1:0] si, sj;
  logic signed [T_W-1:0] tx, ty;
  logic [SLOT_W-1:0] slot_c;
  assign si = idx_r[SIDE_W-1:0];
  assign sj = idx_r[SLOT_W-1:SIDE_W];
  assign tx = fx_r + T_W'(si);
  assign ty = fy_r + T_W'(sj);
  assign slot_c = {ty[SIDE_W-1:0], tx[SIDE_W-1:0]};

  // shared multiplier path: doubled offset and square
  logic signed [D_W-1:0] doff;
  logic signed [T_W+SPAN_W+1:0] mprod;
  logic signed [2*D_W-1:0] sq;
  logic mul_y;
  assign mul_y = (state_r == ST_MUL_Y);
  always_comb begin
    mprod = ($signed({mul_y ? ty : tx, 1'b1})) * $signed({1'b0, span});
    doff = D_W'(mprod - (T_W+SPAN_W+2)'($signed({mul_y ? cy_r : cx_r, 1'b0})));
  end
  logic signed [D_W-1:0] doff_r;
  assign sq = doff_r * doff_r;

  // relief clamp
  logic [RELIEF_W-1:0] rclamp;
  logic signed [RIN_W:0] rdiff;
  assign rclamp = in_relief_value[RIN_W-1] ? '0 :
                  (in_relief_value > RIN_W'(65536)) ? RELIEF_W'(65536) :
                  RELIEF_W'(in_relief_value);
  assign rdiff = $signed({2'b0, rclamp}) - $signed({2'b0, relief_r});

  logic [BUDGET_W-1:0] budget_c;
  assign budget_c = (cfg_budget_r == '0) ? BUDGET_W'(1) : cfg_budget_r;

  logic accept_in;
  assign accept_in = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // scan-order candidate: its slot
  logic [SLOT_W-1:0] best_slot;
  logic signed [T_W-1:0] btx, bty;
  assign btx = fx_r + T_W'(best_r[SIDE_W-1:0]);
  assign bty = fy_r + T_W'(best_r[SLOT_W-1:SIDE_W]);
  assign best_slot = {bty[SIDE_W-1:0], btx[SIDE_W-1:0]};

  always_comb begin
    state_nxt = state_r; relief_nxt = relief_r; ver_nxt = ver_r; valid_nxt = valid_r;
    cand_nxt = cand_r; fx_nxt = fx_r; fy_nxt = fy_r; idx_nxt = idx_r; best_nxt = best_r;
    bestd_nxt = bestd_r; acc_nxt = acc_r; found_nxt = found_r; left_nxt = left_r;
    divsel_nxt = divsel_r; div_cnt_nxt = div_cnt_r;
    ov_nxt = ov_r; os_nxt = os_r; ox_nxt = ox_r; oy_nxt = oy_r; ol_nxt = ol_r;
    div_start = 1'b0; div_a = cx_r; wr_en = 1'b0; cd_wr = 1'b0;
    wr_slot = best_slot; rd_addr = slot_c;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_in) begin
          if (in_action == ACT_RELIEF) begin
            if (rdiff > 19'sd7 || rdiff < -19'sd7) begin
              relief_nxt = rclamp;
              ver_nxt = ver_r + 1'b1;
            end
          end else begin
            div_start = 1'b1;
            div_a = in_centre_x;
            divsel_nxt = 1'b0;
            div_cnt_nxt = 6'(POS_W + 1);
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == 6'd0) begin
          if (!divsel_r) begin
            fx_nxt = div_q - T_W'(GRID_SIDE / 2);
            div_start = 1'b1;
            div_a = cy_r;
            divsel_nxt = 1'b1;
            div_cnt_nxt = 6'(POS_W + 1);
          end else begin
            fy_nxt = div_q - T_W'(GRID_SIDE / 2);
            idx_nxt = '0;
            cand_nxt = '0;
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (valid_r[slot_c] && rd_tx_r == tx[TILE_W-1:0] && rd_ty_r == ty[TILE_W-1:0]
            && rd_v_r == ver_r) begin
          if (idx_r == SLOT_W'(SLOT_COUNT - 1)) state_nxt = ST_SEL_INIT;
          else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = ST_SCAN_RD;
          end
        end else state_nxt = ST_MUL_X;
      end
      ST_MUL_X: begin
        state_nxt = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        acc_nxt = DIST_W'(sq);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cd_wr = 1'b1;
        cand_nxt[idx_r] = 1'b1;
        if (idx_r == SLOT_W'(SLOT_COUNT - 1)) state_nxt = ST_SEL_INIT;
        else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SEL_INIT: begin
        left_nxt = valid_r[0] ? (SLOT_W+1)'(budget_c > BUDGET_W'(SLOT_COUNT) ?
                   BUDGET_W'(SLOT_COUNT) : budget_c) : (SLOT_W+1)'(SLOT_COUNT);
        idx_nxt = '0;
        found_nxt = 1'b0;
        if (cand_r == '0) state_nxt = ST_IDLE;
        else state_nxt = ST_SEL_RD;
      end
      ST_SEL_RD: state_nxt = ST_SEL_CMP;
      ST_SEL_CMP: begin
        if (cand_r[idx_r] && (!found_r || rd_d_r < bestd_r)) begin
          found_nxt = 1'b1;
          best_nxt = idx_r;
          bestd_nxt = rd_d_r;
        end
        if (idx_r == SLOT_W'(SLOT_COUNT - 1)) state_nxt = ST_EMIT;
        else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = ST_SEL_RD;
        end
      end
      ST_EMIT: begin
        if (!ov_r || !out_stall) begin
          wr_en = 1'b1;
          valid_nxt[best_slot] = 1'b1;
          cand_nxt[best_r] = 1'b0;
          ov_nxt = 1'b1;
          os_nxt = best_slot;
          ox_nxt = btx[TILE_W-1:0];
          oy_nxt = bty[TILE_W-1:0];
          ol_nxt = (left_r == (SLOT_W+1)'(1)) ||
                   ((cand_r & ~(SLOT_COUNT'(1) << best_r)) == '0);
          left_nxt = left_r - 1'b1;
          idx_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = ol_nxt ? ST_OUT : ST_SEL_RD;
        end
      end
      ST_OUT: if (!ov_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_SEL_RD || state_r == ST_SEL_CMP) rd_addr = idx_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL_X || state_r == ST_MUL_Y) doff_r <= doff;
    if (state_r == ST_MUL_Y) acc_r <= DIST_W'(sq);
    else acc_r <= acc_nxt;
    if (accept_in) begin
      cx_r <= in_centre_x;
      cy_r <= in_centre_y;
    end
    rd_tx_r <= tx_mem[rd_addr];
    rd_ty_r <= ty_mem[rd_addr];
    rd_v_r  <= vr_mem[rd_addr];
    rd_d_r  <= cd_mem[rd_addr];
    if (cd_wr) cd_mem[idx_r] <= acc_r + DIST_W'(sq);
    if (wr_en) begin
      tx_mem[wr_slot] <= btx[TILE_W-1:0];
      ty_mem[wr_slot] <= bty[TILE_W-1:0];
      vr_mem[wr_slot] <= ver_r;
    end
    fx_r <= fx_nxt; fy_r <= fy_nxt; best_r <= best_nxt; bestd_r <= bestd_nxt;
    os_r <= os_nxt; ox_r <= ox_nxt; oy_r <= oy_nxt; ol_r <= ol_nxt;
    divsel_r <= divsel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; cfg_chunk_r <= CHUNK_W'(100); cfg_budget_r <= BUDGET_W'(4);
      cfg_relief_r <= RELIEF_W'(65536); relief_r <= RELIEF_W'(65536);
      ver_r <= '0; valid_r <= '0; cand_r <= '0; idx_r <= '0; found_r <= 1'b0;
      left_r <= '0; div_cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; relief_r <= relief_nxt; ver_r <= ver_nxt;
      valid_r <= valid_nxt; cand_r <= cand_nxt; idx_r <= idx_nxt; found_r <= found_nxt;
      left_r <= left_nxt; div_cnt_r <= div_cnt_nxt; ov_r <= ov_nxt;
      if (psel && penable && pwrite) begin
        unique case (paddr)
          ADDR_CHUNK:  cfg_chunk_r  <= pwdata[CHUNK_W-1:0];
          ADDR_BUDGET: cfg_budget_r <= pwdata[BUDGET_W-1:0];
          ADDR_RELIEF: cfg_relief_r <= pwdata[RELIEF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_CHUNK:  prdata = DATA_W'(cfg_chunk_r);
      ADDR_BUDGET: prdata = DATA_W'(cfg_budget_r);
      ADDR_RELIEF: prdata = DATA_W'(cfg_relief_r);
      default:     prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  assign out_valid = ov_r;
  assign out_slot_index = os_r;
  assign out_tile_x = ox_r;
  assign out_tile_y = oy_r;
  assign out_build_version = ver_r;
  assign out_last = ol_r;
endmodule

[tb/sv/twrs_checker.sv]
// Scoreboard: tracks the slot table, predicts rebuild results and compares them.
module twrs_checker import twrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]        pwdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_action,
  input  logic signed [POS_W-1:0]  in_centre_x,
  input  logic signed [POS_W-1:0]  in_centre_y,
  input  logic signed [RIN_W-1:0]  in_relief_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [SLOT_W-1:0]        out_slot_index,
  input  logic signed [TILE_W-1:0] out_tile_x,
  input  logic signed [TILE_W-1:0] out_tile_y,
  input  logic [VER_W-1:0]         out_build_version,
  input  logic                     out_last,
  output int                       fail_count,
  output int                       pending_count
);

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [TILE_W-1:0] tx;
    logic [TILE_W-1:0] ty;
    logic [VER_W-1:0]  ver;
    logic              last;
  } rebuild_t;

  rebuild_t rebuild_q[$];

  logic [CHUNK_W-1:0]  chunk_reg;
  logic [BUDGET_W-1:0] budget_reg;
  logic [RELIEF_W-1:0] relief_rst_reg;

  logic [TILE_W-1:0] tile_x_mem[SLOT_COUNT];
  logic [TILE_W-1:0] tile_y_mem[SLOT_COUNT];
  logic              built_mem[SLOT_COUNT];
  logic [VER_W-1:0]  ver_mem[SLOT_COUNT];
  logic [VER_W-1:0]  cur_ver;
  logic [RELIEF_W-1:0] relief_lvl;

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  task automatic apply_relief(logic signed [RIN_W-1:0] rv);
    longint r;
    longint diff;
    r = rv;
    if (r < 0) r = 0;
    if (r > 65536) r = 65536;
    diff = r - longint'(relief_lvl);
    if (diff > 7 || diff < -7) begin
      relief_lvl = r[RELIEF_W-1:0];
      cur_ver = cur_ver + 1'b1;
    end
  endtask

  task automatic predict_rebuilds(logic signed [POS_W-1:0] cx_in,
                                  logic signed [POS_W-1:0] cy_in);
    longint cx, cy, span, fx, fy, tx, ty, dx, dy;
    longint dkey[SLOT_COUNT];
    int slot_of[SLOT_COUNT];
    logic [TILE_W-1:0] wx_of[SLOT_COUNT];
    logic [TILE_W-1:0] wy_of[SLOT_COUNT];
    bit taken[SLOT_COUNT];
    int n, lim, best, s, rx, ry;
    rebuild_t r;
    cx = cx_in;
    cy = cy_in;
    span = longint'(chunk_reg);
    if (span < 1) span = 1;
    if (span > 1024) span = 1024;
    span = span * 16;
    fx = floor_div(cx, span) - GRID_SIDE / 2;
    fy = floor_div(cy, span) - GRID_SIDE / 2;
    n = 0;
    for (int j = 0; j < GRID_SIDE; j++) begin
      for (int i = 0; i < GRID_SIDE; i++) begin
        tx = fx + i;
        ty = fy + j;
        rx = int'(((tx % GRID_SIDE) + GRID_SIDE) % GRID_SIDE);
        ry = int'(((ty % GRID_SIDE) + GRID_SIDE) % GRID_SIDE);
        s = ry * GRID_SIDE + rx;
        if (built_mem[s] && tile_x_mem[s] == tx[TILE_W-1:0] &&
            tile_y_mem[s] == ty[TILE_W-1:0] && ver_mem[s] == cur_ver)
          continue;
        dx = (2 * tx + 1) * span - 2 * cx;
        dy = (2 * ty + 1) * span - 2 * cy;
        dkey[n] = dx * dx + dy * dy;
        slot_of[n] = s;
        wx_of[n] = tx[TILE_W-1:0];
        wy_of[n] = ty[TILE_W-1:0];
        taken[n] = 1'b0;
        n++;
      end
    end
    lim = n;
    if (built_mem[0]) begin
      best = (budget_reg == '0) ? 1 : int'(budget_reg);
      if (best < lim) lim = best;
    end
    for (int k = 0; k < lim; k++) begin
      // nearest first, earliest in scan order on ties
      best = -1;
      for (int c = 0; c < n; c++)
        if (!taken[c] && (best < 0 || dkey[c] < dkey[best])) best = c;
      taken[best] = 1'b1;
      s = slot_of[best];
      tile_x_mem[s] = wx_of[best];
      tile_y_mem[s] = wy_of[best];
      built_mem[s] = 1'b1;
      ver_mem[s] = cur_ver;
      r.slot = s[SLOT_W-1:0];
      r.tx = wx_of[best];
      r.ty = wy_of[best];
      r.ver = cur_ver;
      r.last = (k == lim - 1);
      rebuild_q.push_back(r);
    end
  endtask

  task automatic note_fail(string what);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH %s", what);
  endtask

  always @(posedge clk) begin
    rebuild_t e;
    if (!rst_n) begin
      fail_count = 0;
      chunk_reg = CHUNK_W'(100);
      budget_reg = BUDGET_W'(4);
      relief_rst_reg = RELIEF_W'(65536);
      relief_lvl = RELIEF_W'(65536);
      cur_ver = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        built_mem[i] = 1'b0;
        tile_x_mem[i] = '0;
        tile_y_mem[i] = '0;
        ver_mem[i] = '0;
      end
      rebuild_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_CHUNK:  chunk_reg = pwdata[CHUNK_W-1:0];
          ADDR_BUDGET: budget_reg = pwdata[BUDGET_W-1:0];
          ADDR_RELIEF: relief_rst_reg = pwdata[RELIEF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_action == ACT_RELIEF) apply_relief(in_relief_value);
        else predict_rebuilds(in_centre_x, in_centre_y);
      end
      if (out_valid && !out_stall) begin
        if (rebuild_q.size() == 0) begin
          note_fail($sformatf("unexpected transaction slot=%0d", out_slot_index));
        end else begin
          e = rebuild_q.pop_front();
          if (out_slot_index !== e.slot || out_tile_x !== e.tx || out_tile_y !== e.ty ||
              out_build_version !== e.ver || out_last !== e.last)
            note_fail($sformatf(
              "exp slot=%0d x=%h y=%h ver=%0d last=%0d got slot=%0d x=%h y=%h ver=%0d last=%0d",
              e.slot, e.tx, e.ty, e.ver, e.last, out_slot_index, out_tile_x, out_tile_y,
              out_build_version, out_last));
        end
      end
    end
    pending_count = rebuild_q.size();
  end

endmodule

[tb/sv/tile_window_rebuild_scheduler_tb.sv]
// Testbench top: clock, reset, stimulus, register writes and final verdict.
module tile_window_rebuild_scheduler_tb;
  import twrs_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int DRAIN_CYCLES = 700;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic in_valid, in_stall, in_action;
  logic signed [POS_W-1:0] in_centre_x, in_centre_y;
  logic signed [RIN_W-1:0] in_relief_value;
  logic out_valid, out_stall, out_last;
  logic [SLOT_W-1:0] out_slot_index;
  logic signed [TILE_W-1:0] out_tile_x, out_tile_y;
  logic [VER_W-1:0] out_build_version;

  int fail_count, pending_count;
  int send_idle_pct, recv_idle_pct;
  int hold_req;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  longint walk_x, walk_y;

  tile_window_rebuild_scheduler dut (.*);

  twrs_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure; a hold request forces a long stall
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic reg_write(logic [PADDR_W-1:0] a, logic [DATA_W-1:0] d);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0; paddr = a; pwdata = d;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic send(logic act, logic signed [POS_W-1:0] cx, logic signed [POS_W-1:0] cy,
                      logic signed [RIN_W-1:0] rv);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 0;
      repeat ($urandom_range(6)) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1; in_action = act; in_centre_x = cx; in_centre_y = cy;
    in_relief_value = rv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly a random walk so windows overlap; sometimes a jump anywhere
  task automatic random_item(int chunk);
    longint step;
    step = longint'(chunk) * 16 * 3;
    if ($urandom_range(99) < 22) begin
      send(ACT_RELIEF, POS_W'($urandom), POS_W'($urandom),
           ($urandom_range(1)) ? RIN_W'($urandom) : RIN_W'($urandom_range(65560, 65510)));
    end else begin
      if ($urandom_range(99) < 10) begin
        walk_x = longint'(signed'(POS_W'($urandom)));
        walk_y = longint'(signed'(POS_W'($urandom)));
      end else begin
        walk_x += longint'($urandom_range(32'(2 * step))) - step;
        walk_y += longint'($urandom_range(32'(2 * step))) - step;
      end
      send(ACT_MOVE, POS_W'(walk_x), POS_W'(walk_y), RIN_W'($urandom));
    end
  endtask

  initial begin
    int chunks[4];
    chunks = '{100, 1, 1024, 0};
    rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; in_action = ACT_MOVE; in_centre_x = '0; in_centre_y = '0;
    in_relief_value = '0;
    hold_req = 0;
    send_idle_pct = 22; recv_idle_pct = 69;
    walk_x = 0; walk_y = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: first build, repeat, neighbor shift, relief clamps, extremes
    send(ACT_MOVE, '0, '0, '0);
    send(ACT_MOVE, '0, '0, '0);
    send(ACT_MOVE, 28'sd1600, -28'sd1600, '0);
    send(ACT_RELIEF, '0, '0, -18'sd131072);
    send(ACT_RELIEF, '0, '0, 18'sd3);
    send(ACT_RELIEF, '0, '0, 18'sd131071);
    send(ACT_RELIEF, '0, '0, 18'sd65529);
    send(ACT_RELIEF, '0, '0, 18'sd65528);
    send(ACT_MOVE, 28'sd1600, -28'sd1600, '0);
    send(ACT_MOVE, 28'sh7FFFFFF, 28'sh7FFFFFF, -18'sd1);
    send(ACT_MOVE, 28'sh8000000, 28'sh8000000, '0);
    send(ACT_MOVE, -28'sd1, -28'sd1, '0);
    send(ACT_MOVE, 28'sh5555555, 28'shAAAAAAA, 18'h2AAAA);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        1: begin
          reg_write(ADDR_CHUNK, 32'd1); reg_write(ADDR_BUDGET, 32'd64);
          reg_write(ADDR_RELIEF, 32'd0);
        end
        2: begin
          reg_write(ADDR_CHUNK, 32'd1024); reg_write(ADDR_BUDGET, 32'd1);
          reg_write(ADDR_RELIEF, 32'h1FFFF);
        end
        3: begin
          reg_write(ADDR_CHUNK, 32'd0); reg_write(ADDR_BUDGET, 32'd0);
        end
        default: ;
      endcase
      send_idle_pct = (p == 0) ? 22 : (p == 1) ? 69 : 0;
      recv_idle_pct = (p == 0) ? 69 : (p == 1) ? 22 : 0;
      if (p == 1) begin
        send(ACT_MOVE, 28'sh7FFFFFF, 28'sh0, '0);
        send(ACT_MOVE, 28'sh8000000, 28'sh7FFFFF0, '0);
      end
      for (int k = 0; k < 50; k++) begin
        if (p == 1 && k == 10) hold_req++;
        if (p == 2 && k == 25) drain();
        random_item(chunks[p] == 0 ? 1 : chunks[p]);
      end
      drain();
    end

    // chunk above range saturates; then a few version bumps make the window stale again
    reg_write(ADDR_CHUNK, 32'd2047); reg_write(ADDR_BUDGET, 32'd127);
    send(ACT_MOVE, 28'sh1234560, -28'sh0654321, '0);
    send(ACT_MOVE, 28'sh1234560, -28'sh0654321, '0);
    drain();
    for (int k = 0; k < 4; k++)
      send(ACT_RELIEF, '0, '0, (k % 2 == 0) ? 18'sd0 : 18'sd65536);
    send(ACT_MOVE, 28'sh1234560, -28'sh0654321, '0);
    send(ACT_MOVE, 28'sh1234570, -28'sh0754321, '0);
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
